// ===== hw/rtl/rffe_pkg.sv =====
// Shared types, constants and decode tables for the referee frame field extractor.
package rffe_pkg;

  localparam logic [7:0]  START_BYTE_RESET = 8'hA5;
  localparam logic [2:0]  REG_START_BYTE   = 3'd0;

  localparam logic [15:0] CMD_GAME_STATUS  = 16'd1;
  localparam logic [15:0] CMD_ROBOT_HP     = 16'd3;
  localparam logic [15:0] CMD_REF_WARNING  = 16'd260;
  localparam logic [15:0] CMD_ROBOT_STATUS = 16'd201;
  localparam logic [15:0] CMD_POWER_HEAT   = 16'd514;
  localparam logic [15:0] CMD_SHOOT_DATA   = 16'd519;

  localparam logic [5:0]  POS_HUNT      = 6'd0;
  localparam logic [5:0]  POS_CMD_HI    = 6'd5;
  localparam logic [5:0]  POS_CMD_LO    = 6'd6;
  localparam logic [5:0]  POS_PAYLOAD   = 6'd7;
  localparam logic [5:0]  POS_MAX       = 6'd34;

  localparam logic [4:0]  FC_STAGE          = 5'd0;
  localparam logic [4:0]  FC_REMAIN_TIME    = 5'd1;
  localparam logic [4:0]  FC_RED_SENTRY_HP  = 5'd2;
  localparam logic [4:0]  FC_BLUE_SENTRY_HP = 5'd3;
  localparam logic [4:0]  FC_WARNING        = 5'd4;
  localparam logic [4:0]  FC_FOUL_ROBOT     = 5'd5;
  localparam logic [4:0]  FC_ROBOT_ID       = 5'd6;
  localparam logic [4:0]  FC_ROBOT_LEVEL    = 5'd7;
  localparam logic [4:0]  FC_ROBOT_HP       = 5'd8;
  localparam logic [4:0]  FC_COOLING        = 5'd9;
  localparam logic [4:0]  FC_HEAT_LIMIT     = 5'd10;
  localparam logic [4:0]  FC_SPEED_LIMIT    = 5'd11;
  localparam logic [4:0]  FC_COOLING_2      = 5'd12;
  localparam logic [4:0]  FC_HEAT_LIMIT_2   = 5'd13;
  localparam logic [4:0]  FC_SPEED_LIMIT_2  = 5'd14;
  localparam logic [4:0]  FC_POWER_LIMIT    = 5'd15;
  localparam logic [4:0]  FC_VOLTAGE        = 5'd16;
  localparam logic [4:0]  FC_CURRENT        = 5'd17;
  localparam logic [4:0]  FC_POWER          = 5'd18;
  localparam logic [4:0]  FC_BARREL_HEAT    = 5'd19;
  localparam logic [4:0]  FC_BARREL_HEAT_2  = 5'd20;
  localparam logic [4:0]  FC_LAUNCH_FREQ    = 5'd21;
  localparam logic [4:0]  FC_LAUNCH_SPEED   = 5'd22;

  localparam logic [3:0]  STAGE_MAX   = 4'd5;
  localparam logic [7:0]  WARN_YELLOW = 8'd1;
  localparam logic [7:0]  WARN_FAIL   = 8'd3;

  localparam logic [7:0]  ID_RED_HERO       = 8'd1;
  localparam logic [7:0]  ID_RED_INF_3      = 8'd3;
  localparam logic [7:0]  ID_RED_INF_4      = 8'd4;
  localparam logic [7:0]  ID_RED_INF_5      = 8'd5;
  localparam logic [7:0]  ID_RED_SENTRY     = 8'd7;
  localparam logic [7:0]  ID_BLUE_HERO      = 8'd101;
  localparam logic [7:0]  ID_BLUE_INF_3     = 8'd103;
  localparam logic [7:0]  ID_BLUE_INF_4     = 8'd104;
  localparam logic [7:0]  ID_BLUE_INF_5     = 8'd105;
  localparam logic [7:0]  ID_BLUE_SENTRY    = 8'd107;

  typedef enum logic [2:0] {
    FRAME_NONE,
    FRAME_GAME_STATUS,
    FRAME_ROBOT_HP,
    FRAME_REF_WARNING,
    FRAME_ROBOT_STATUS,
    FRAME_POWER_HEAT,
    FRAME_SHOOT_DATA
  } frame_t;

  typedef enum logic [2:0] {
    KIND_PLAIN,
    KIND_GROUP_A,
    KIND_GROUP_B,
    KIND_STAGE,
    KIND_WARN,
    KIND_ID
  } kind_t;

  typedef struct packed {
    logic       hit;
    logic       first;
    logic       last;
    logic [4:0] code;
    kind_t      kind;
  } field_info_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic [4:0] code;
    kind_t      kind;
  } queue_item_t;

  function automatic frame_t frame_decode(logic [15:0] cmd);
    frame_t fr;
    fr = FRAME_NONE;
    if (cmd == CMD_GAME_STATUS)  fr = FRAME_GAME_STATUS;
    if (cmd == CMD_ROBOT_HP)     fr = FRAME_ROBOT_HP;
    if (cmd == CMD_REF_WARNING)  fr = FRAME_REF_WARNING;
    if (cmd == CMD_ROBOT_STATUS) fr = FRAME_ROBOT_STATUS;
    if (cmd == CMD_POWER_HEAT)   fr = FRAME_POWER_HEAT;
    if (cmd == CMD_SHOOT_DATA)   fr = FRAME_SHOOT_DATA;
    return fr;
  endfunction

  function automatic logic [4:0] frame_length(frame_t fr);
    logic [4:0] len;
    case (fr)
      FRAME_GAME_STATUS:  len = 5'd3;
      FRAME_ROBOT_HP:     len = 5'd28;
      FRAME_REF_WARNING:  len = 5'd2;
      FRAME_ROBOT_STATUS: len = 5'd26;
      FRAME_POWER_HEAT:   len = 5'd16;
      FRAME_SHOOT_DATA:   len = 5'd7;
      default:            len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic field_info_t field_lookup(frame_t fr, logic [4:0] p);
    field_info_t info;
    logic [4:0]  off;
    logic [2:0]  len;
    info = '0;
    off  = '0;
    len  = '0;
    case (fr)
      FRAME_GAME_STATUS: begin
        case (p)
          5'd0: begin
            info.hit = 1'b1; off = 5'd0; len = 3'd1;
            info.code = FC_STAGE; info.kind = KIND_STAGE;
          end
          5'd1, 5'd2: begin
            info.hit = 1'b1; off = 5'd1; len = 3'd2;
            info.code = FC_REMAIN_TIME; info.kind = KIND_PLAIN;
          end
          default: info.hit = 1'b0;
        endcase
      end
      FRAME_ROBOT_HP: begin
        case (p)
          5'd10, 5'd11: begin
            info.hit = 1'b1; off = 5'd10; len = 3'd2;
            info.code = FC_RED_SENTRY_HP; info.kind = KIND_PLAIN;
          end
          5'd26, 5'd27: begin
            info.hit = 1'b1; off = 5'd26; len = 3'd2;
            info.code = FC_BLUE_SENTRY_HP; info.kind = KIND_PLAIN;
          end
          default: info.hit = 1'b0;
        endcase
      end
      FRAME_REF_WARNING: begin
        case (p)
          5'd0: begin
            info.hit = 1'b1; off = 5'd0; len = 3'd1;
            info.code = FC_WARNING; info.kind = KIND_WARN;
          end
          5'd1: begin
            info.hit = 1'b1; off = 5'd1; len = 3'd1;
            info.code = FC_FOUL_ROBOT; info.kind = KIND_PLAIN;
          end
          default: info.hit = 1'b0;
        endcase
      end
      FRAME_ROBOT_STATUS: begin
        case (p)
          5'd0: begin
            info.hit = 1'b1; off = 5'd0; len = 3'd1;
            info.code = FC_ROBOT_ID; info.kind = KIND_ID;
          end
          5'd1: begin
            info.hit = 1'b1; off = 5'd1; len = 3'd1;
            info.code = FC_ROBOT_LEVEL; info.kind = KIND_PLAIN;
          end
          5'd2, 5'd3: begin
            info.hit = 1'b1; off = 5'd2; len = 3'd2;
            info.code = FC_ROBOT_HP; info.kind = KIND_PLAIN;
          end
          5'd6, 5'd7: begin
            info.hit = 1'b1; off = 5'd6; len = 3'd2;
            info.code = FC_COOLING; info.kind = KIND_PLAIN;
          end
          5'd8, 5'd9: begin
            info.hit = 1'b1; off = 5'd8; len = 3'd2;
            info.code = FC_HEAT_LIMIT; info.kind = KIND_PLAIN;
          end
          5'd10, 5'd11: begin
            info.hit = 1'b1; off = 5'd10; len = 3'd2;
            info.code = FC_SPEED_LIMIT; info.kind = KIND_PLAIN;
          end
          5'd12, 5'd13: begin
            info.hit = 1'b1; off = 5'd12; len = 3'd2;
            info.code = FC_COOLING_2; info.kind = KIND_GROUP_A;
          end
          5'd14, 5'd15: begin
            info.hit = 1'b1; off = 5'd14; len = 3'd2;
            info.code = FC_HEAT_LIMIT_2; info.kind = KIND_GROUP_A;
          end
          5'd16, 5'd17: begin
            info.hit = 1'b1; off = 5'd16; len = 3'd2;
            info.code = FC_SPEED_LIMIT_2; info.kind = KIND_GROUP_A;
          end
          5'd18, 5'd19: begin
            info.hit = 1'b1; off = 5'd18; len = 3'd2;
            info.code = FC_COOLING_2; info.kind = KIND_GROUP_B;
          end
          5'd20, 5'd21: begin
            info.hit = 1'b1; off = 5'd20; len = 3'd2;
            info.code = FC_HEAT_LIMIT_2; info.kind = KIND_GROUP_B;
          end
          5'd22, 5'd23: begin
            info.hit = 1'b1; off = 5'd22; len = 3'd2;
            info.code = FC_SPEED_LIMIT_2; info.kind = KIND_GROUP_B;
          end
          5'd24, 5'd25: begin
            info.hit = 1'b1; off = 5'd24; len = 3'd2;
            info.code = FC_POWER_LIMIT; info.kind = KIND_PLAIN;
          end
          default: info.hit = 1'b0;
        endcase
      end
      FRAME_POWER_HEAT: begin
        case (p)
          5'd0, 5'd1: begin
            info.hit = 1'b1; off = 5'd0; len = 3'd2;
            info.code = FC_VOLTAGE; info.kind = KIND_PLAIN;
          end
          5'd2, 5'd3: begin
            info.hit = 1'b1; off = 5'd2; len = 3'd2;
            info.code = FC_CURRENT; info.kind = KIND_PLAIN;
          end
          5'd4, 5'd5, 5'd6, 5'd7: begin
            info.hit = 1'b1; off = 5'd4; len = 3'd4;
            info.code = FC_POWER; info.kind = KIND_PLAIN;
          end
          5'd10, 5'd11: begin
            info.hit = 1'b1; off = 5'd10; len = 3'd2;
            info.code = FC_BARREL_HEAT; info.kind = KIND_PLAIN;
          end
          5'd12, 5'd13: begin
            info.hit = 1'b1; off = 5'd12; len = 3'd2;
            info.code = FC_BARREL_HEAT_2; info.kind = KIND_GROUP_A;
          end
          5'd14, 5'd15: begin
            info.hit = 1'b1; off = 5'd14; len = 3'd2;
            info.code = FC_BARREL_HEAT_2; info.kind = KIND_GROUP_B;
          end
          default: info.hit = 1'b0;
        endcase
      end
      FRAME_SHOOT_DATA: begin
        case (p)
          5'd2: begin
            info.hit = 1'b1; off = 5'd2; len = 3'd1;
            info.code = FC_LAUNCH_FREQ; info.kind = KIND_PLAIN;
          end
          5'd3, 5'd4, 5'd5, 5'd6: begin
            info.hit = 1'b1; off = 5'd3; len = 3'd4;
            info.code = FC_LAUNCH_SPEED; info.kind = KIND_PLAIN;
          end
          default: info.hit = 1'b0;
        endcase
      end
      default: info.hit = 1'b0;
    endcase
    info.first = (p == off);
    info.last  = ({1'b0, p} == ({1'b0, off} + {3'b000, len} - 6'd1));
    return info;
  endfunction

endpackage

// ===== hw/rtl/rffe_front.sv =====
// Front end: tracks frame position, decodes the command and tags payload bytes.
module rffe_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           start_byte,
  input  logic                 take,
  input  logic [7:0]           rx_byte,
  output logic                 push,
  output rffe_pkg::queue_item_t push_item
);
  import rffe_pkg::*;

  logic [5:0]  pos;
  logic [5:0]  pos_next;
  logic [7:0]  cmd_hi;
  frame_t      frame;
  frame_t      frame_next;
  frame_t      frame_dec;
  logic [5:0]  pay_off;
  logic [4:0]  p;
  logic [4:0]  flen;
  field_info_t info;
  logic        in_payload;

  assign frame_dec  = frame_decode({cmd_hi, rx_byte});
  assign pay_off    = pos - POS_PAYLOAD;
  assign p          = pay_off[4:0];
  assign flen       = frame_length(frame);
  assign info       = field_lookup(frame, p);
  assign in_payload = (pos >= POS_PAYLOAD);

  always_comb begin
    pos_next   = pos;
    frame_next = frame;
    if (pos == POS_HUNT) begin
      if (rx_byte == start_byte) pos_next = pos + 6'd1;
    end else if (pos < POS_CMD_LO) begin
      pos_next = pos + 6'd1;
    end else if (pos == POS_CMD_LO) begin
      frame_next = frame_dec;
      pos_next   = (frame_dec != FRAME_NONE) ? POS_PAYLOAD : POS_HUNT;
    end else begin
      pos_next = (({1'b0, p} + 6'd1) >= {1'b0, flen}) ? POS_HUNT : pos + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= POS_HUNT;
      frame <= FRAME_NONE;
    end else if (take) begin
      pos   <= pos_next;
      frame <= frame_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && pos == POS_CMD_HI) cmd_hi <= rx_byte;
  end

  assign push            = take && in_payload && info.hit;
  assign push_item.data  = rx_byte;
  assign push_item.first = info.first;
  assign push_item.last  = info.last;
  assign push_item.code  = info.code;
  assign push_item.kind  = info.kind;

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= POS_MAX)
    else $error("frame position out of range");
  a_payload_known: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> frame != FRAME_NONE)
    else $error("payload position without a known frame");
  a_hunt_after_tail: assert property (@(posedge clk) disable iff (rst)
    (take && in_payload && ({1'b0, p} + 6'd1 == {1'b0, flen})) |=> pos == POS_HUNT)
    else $error("frame tail did not return to hunting");
`endif

endmodule

// ===== hw/rtl/rffe_queue.sv =====
// Short queue of tagged payload bytes between front and back ends.
module rffe_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rffe_pkg::queue_item_t push_item,
  output logic                  full,
  input  logic                  pop,
  output rffe_pkg::queue_item_t pop_item,
  output logic                  empty
);
  import rffe_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  queue_item_t      slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == FULL_COUNT);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_item;
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= FULL_COUNT)
    else $error("queue count out of range");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("pop from empty queue");
`endif

endmodule

// ===== hw/rtl/rffe_back.sv =====
// Back end: assembles fields, applies value mapping and robot groups, holds the result.
module rffe_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  empty,
  input  rffe_pkg::queue_item_t item,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [4:0]            field_code,
  output logic [31:0]           field_value
);
  import rffe_pkg::*;

  logic [31:0] acc;
  logic [31:0] acc_next;
  logic [7:0]  robot_identity;
  logic        group_a;
  logic        group_b;
  logic        emit;
  logic [31:0] value;

  assign group_a = (robot_identity == ID_RED_INF_3)  || (robot_identity == ID_RED_INF_4) ||
                   (robot_identity == ID_RED_INF_5)  || (robot_identity == ID_RED_SENTRY) ||
                   (robot_identity == ID_BLUE_INF_3) || (robot_identity == ID_BLUE_INF_4) ||
                   (robot_identity == ID_BLUE_INF_5) || (robot_identity == ID_BLUE_SENTRY);
  assign group_b = (robot_identity == ID_RED_HERO) || (robot_identity == ID_BLUE_HERO);

  assign pop      = !empty && (!out_valid || !out_stall);
  assign acc_next = item.first ? {24'd0, item.data} : {acc[23:0], item.data};

  always_comb begin
    emit  = item.last;
    value = acc_next;
    case (item.kind)
      KIND_STAGE: begin
        value = {28'd0, item.data[7:4]};
        emit  = item.last && (item.data[7:4] <= STAGE_MAX);
      end
      KIND_WARN: begin
        value = {24'd0, item.data - 8'd1};
        emit  = item.last && (item.data >= WARN_YELLOW) && (item.data <= WARN_FAIL);
      end
      KIND_GROUP_A: emit = item.last && group_a;
      KIND_GROUP_B: emit = item.last && group_b;
      default:      emit = item.last;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      robot_identity <= '0;
    end else begin
      if (pop) out_valid <= emit;
      else if (!out_stall) out_valid <= 1'b0;
      if (pop && item.last && item.kind == KIND_ID) robot_identity <= item.data;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) acc <= acc_next;
    if (pop && emit) begin
      field_code  <= item.code;
      field_value <= value;
    end
  end

`ifndef NO_ASSERTIONS
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> field_code <= FC_LAUNCH_SPEED)
    else $error("field code out of range");
  a_no_pop_while_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !pop)
    else $error("queue popped while result held");
  a_stage_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && field_code == FC_STAGE) |-> field_value <= 32'd5)
    else $error("stage value out of range");
`endif

endmodule

// ===== hw/rtl/referee_frame_field_extractor_top.sv =====
// Top level of the referee frame field extractor: register port, front, queue and back.
//
//   port set        dir  transfer when             payload
//   in              in   in_valid & !in_stall      rx_byte
//   out             out  out_valid & !out_stall    field_code, field_value
//   apb             in   psel & penable & pwrite   paddr, pwdata (start_byte at 0)
//
// One byte per cycle is taken while the queue has room; the last byte of a field
// passes through a queue slot and the result register before the result is shown.
// in_stall rises only when the queue is full, once QUEUE_DEPTH field bytes wait
// behind a result held by a stalled output. Reset is synchronous; it returns to
// hunting, clears the robot id and sets start_byte to 0xA5.
module referee_frame_field_extractor_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  field_code,
  output logic [31:0] field_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rffe_pkg::*;

  logic [7:0]  start_byte;
  logic        take;
  logic        push;
  queue_item_t push_item;
  logic        full;
  logic        pop;
  queue_item_t pop_item;
  logic        empty;

  assign pready   = 1'b1;
  assign prdata   = (paddr == REG_START_BYTE) ? {24'd0, start_byte} : 32'd0;
  assign in_stall = full;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_START_BYTE) begin
      start_byte <= pwdata[7:0];
    end
  end

  rffe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start_byte (start_byte),
    .take       (take),
    .rx_byte    (rx_byte),
    .push       (push),
    .push_item  (push_item)
  );

  rffe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  rffe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (empty),
    .item        (pop_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .field_code  (field_code),
    .field_value (field_value)
  );

endmodule
